// ===== sv/irb_pkg.sv =====
// Package for the infrared ring bearing estimator: constants, payload types, direction tables.
`default_nettype none
package irb_pkg;

    localparam int SENSOR_COUNT      = 16;
    localparam int READING_BITS      = 12;
    localparam int READING_MAX       = (1 << READING_BITS) - 1;
    localparam int POS_BITS          = 4;
    localparam int POS_COUNT         = 1 << POS_BITS;
    localparam int UNIT_BITS         = 18;
    localparam int WEIGHT_BITS       = READING_BITS + 1;
    localparam int PROD_BITS         = WEIGHT_BITS + UNIT_BITS;
    localparam int SUM_BITS          = 34;
    localparam int CORDIC_BITS       = SUM_BITS + 3;
    localparam int ANGLE_BITS        = 16;
    localparam int Z_BITS            = 18;
    localparam int CORDIC_STEPS      = 16;
    localparam int STEP_BITS         = 4;
    localparam int CORDIC_START      = 19898;
    localparam int DEFAULT_THRESHOLD = 4000;
    localparam int HALF_TURN         = 32768;

    typedef struct packed {
        logic [POS_BITS-1:0]     sensor_position;
        logic [READING_BITS-1:0] reading;
        logic                    packet_end;
    } irb_in_t;

    typedef struct packed {
        logic                         ball_seen;
        logic signed [ANGLE_BITS-1:0] bearing;
        logic [POS_BITS-1:0]          strongest_position;
        logic [READING_BITS-1:0]      strongest_reading;
    } irb_out_t;

    typedef logic [POS_COUNT-1:0][UNIT_BITS-1:0] unit_lut_t;

    function automatic logic signed [Z_BITS-1:0] atan_unit(input logic [STEP_BITS-1:0] i);
        logic signed [Z_BITS-1:0] v;
        case (i)
            4'd0:    v = 18'sd8192;
            4'd1:    v = 18'sd4836;
            4'd2:    v = 18'sd2555;
            4'd3:    v = 18'sd1297;
            4'd4:    v = 18'sd651;
            4'd5:    v = 18'sd326;
            4'd6:    v = 18'sd163;
            4'd7:    v = 18'sd81;
            4'd8:    v = 18'sd41;
            4'd9:    v = 18'sd20;
            4'd10:   v = 18'sd10;
            4'd11:   v = 18'sd5;
            4'd12:   v = 18'sd3;
            4'd13:   v = 18'sd1;
            4'd14:   v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

    // Q15 unit vector of every sensor direction, rotation-mode CORDIC at elaboration
    function automatic unit_lut_t build_unit_lut(input bit want_sin);
        unit_lut_t lut;
        longint    a;
        longint    x;
        longint    y;
        longint    dx;
        longint    dy;
        bit        flip;
        lut = '0;
        for (int p = 0; p < POS_COUNT; p++) begin
            a = (longint'(p) * 65536 / SENSOR_COUNT) % 65536;
            flip = 1'b0;
            if (a >= 32768) a = a - 65536;
            if (a > 16384) begin
                a = a - 32768;
                flip = 1'b1;
            end else if (a < -16384) begin
                a = a + 32768;
                flip = 1'b1;
            end
            x = CORDIC_START;
            y = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (a >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    a = a - longint'(atan_unit(STEP_BITS'(i)));
                end else begin
                    x = x + dx;
                    y = y - dy;
                    a = a + longint'(atan_unit(STEP_BITS'(i)));
                end
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            lut[p] = want_sin ? UNIT_BITS'(y) : UNIT_BITS'(x);
        end
        return lut;
    endfunction

    localparam unit_lut_t COS_LUT = build_unit_lut(1'b0);
    localparam unit_lut_t SIN_LUT = build_unit_lut(1'b1);

endpackage
`default_nettype wire

// ===== sv/ir_ring_bearing_estimator.sv =====
// Infrared ring bearing estimator: accumulates weighted sensor vectors, CORDIC arctangent.
//
// Input channel in_valid/in_stall/in_data carries one reading per transaction with its
// sensor position and a packet_end mark. Output channel out_valid/out_stall/out_data
// carries one result per packet: ball_seen, held bearing and the strongest reading.
// cfg_wr_en/cfg_wr_data write detect_threshold (reset 4000); write only while idle.
//
// Each reading is worked in turn: the accepting cycle multiplies weight by the cosine,
// the next adds it and multiplies by the sine, and then that product is added. Both
// products share one multiplier. A reading with packet_end then passes through PREP,
// which loads the vector, 16 iterations of the shared vectoring CORDIC stage, and FIN,
// which writes the result register; PREP skips the iterations when nothing was detected
// or both sums are 0. in_stall is high throughout; a result then sits in the output
// register, and the next packet is accepted while it waits. A packet end that finds the
// output register still full and stalled holds until it is taken.
// Reset clears the sums, held bearing and output valid; the lowest reading resets to max.
`default_nettype none
module ir_ring_bearing_estimator
    import irb_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_wr_en,
    input  wire logic [READING_BITS-1:0] cfg_wr_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire irb_in_t                 in_data,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output irb_out_t                     out_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC_X = 3'd1;
    localparam logic [2:0] S_ACC_Y = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_ITER  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [READING_BITS-1:0]        thr_reg;
    logic signed [SUM_BITS-1:0]     sx_reg, sy_reg;
    logic [READING_BITS-1:0]        low_reg;
    logic [POS_BITS-1:0]            low_pos_reg;
    logic                           any_reg;
    logic signed [ANGLE_BITS-1:0]   held_reg;
    logic [POS_BITS-1:0]            pos_reg;
    logic [READING_BITS-1:0]        weight_reg;
    logic                           last_reg;
    logic signed [PROD_BITS-1:0]    prod_reg;
    logic signed [CORDIC_BITS-1:0]  cx_reg, cy_reg;
    logic signed [Z_BITS-1:0]       z_reg;
    logic                           zero_reg;
    logic [STEP_BITS-1:0]           step_reg;
    logic                           out_valid_reg;
    irb_out_t                       out_reg;

    logic                           in_take;
    logic                           det;
    logic [READING_BITS-1:0]        weight_in;
    logic signed [WEIGHT_BITS-1:0]  mul_a;
    logic signed [UNIT_BITS-1:0]    mul_b;
    logic signed [PROD_BITS-1:0]    mul_p;
    logic signed [CORDIC_BITS-1:0]  sx_ext, sy_ext;
    logic signed [CORDIC_BITS-1:0]  dx, dy;
    logic                           y_pos;
    logic                           out_free;
    logic signed [ANGLE_BITS-1:0]   new_bearing;

    function automatic logic signed [SUM_BITS-1:0] sat_add(
        input logic signed [SUM_BITS-1:0]  s,
        input logic signed [PROD_BITS-1:0] p
    );
        logic signed [SUM_BITS:0] t;
        logic signed [SUM_BITS-1:0] r;
        t = (SUM_BITS+1)'(s) + (SUM_BITS+1)'(p);
        if (t[SUM_BITS] != t[SUM_BITS-1])
        begin
            r = t[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
        end
        else
        begin
            r = t[SUM_BITS-1:0];
        end
        return r;
    endfunction

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign det       = (in_data.reading < thr_reg);
    assign weight_in = det ? (READING_BITS'(READING_MAX) - in_data.reading) : '0;

    // shared multiplier: cosine at accept, sine in the following cycle
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            mul_a = $signed({1'b0, weight_in});
            mul_b = $signed(COS_LUT[in_data.sensor_position]);
        end
        else
        begin
            mul_a = $signed({1'b0, weight_reg});
            mul_b = $signed(SIN_LUT[pos_reg]);
        end
    end
    assign mul_p = mul_a * mul_b;

    assign sx_ext = CORDIC_BITS'(sx_reg);
    assign sy_ext = CORDIC_BITS'(sy_reg);
    assign dx     = cy_reg >>> step_reg;
    assign dy     = cx_reg >>> step_reg;
    assign y_pos  = !cy_reg[CORDIC_BITS-1] && (cy_reg != '0);
    assign new_bearing = any_reg ? (zero_reg ? '0 : z_reg[ANGLE_BITS-1:0]) : held_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_take) state_next = S_ACC_X;
            S_ACC_X: state_next = S_ACC_Y;
            S_ACC_Y: state_next = last_reg ? S_PREP : S_IDLE;
            S_PREP:  state_next = (any_reg && !((sx_reg == '0) && (sy_reg == '0))) ?
                                  S_ITER : S_FIN;
            S_ITER:  if (step_reg == STEP_BITS'(CORDIC_STEPS - 1)) state_next = S_FIN;
            S_FIN:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            thr_reg       <= READING_BITS'(DEFAULT_THRESHOLD);
            sx_reg        <= '0;
            sy_reg        <= '0;
            low_reg       <= READING_BITS'(READING_MAX);
            low_pos_reg   <= '0;
            any_reg       <= 1'b0;
            held_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en) thr_reg <= cfg_wr_data;
            if ((state_reg == S_FIN) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        if (in_data.reading < low_reg)
                        begin
                            low_reg     <= in_data.reading;
                            low_pos_reg <= in_data.sensor_position;
                        end
                        if (det) any_reg <= 1'b1;
                    end
                end
                S_ACC_X: sx_reg <= sat_add(sx_reg, prod_reg);
                S_ACC_Y: sy_reg <= sat_add(sy_reg, prod_reg);
                S_PREP:  step_reg <= '0;
                S_ITER:  step_reg <= step_reg + 1'b1;
                S_FIN:
                begin
                    if (out_free)
                    begin
                        held_reg      <= new_bearing;
                        sx_reg        <= '0;
                        sy_reg        <= '0;
                        low_reg       <= READING_BITS'(READING_MAX);
                        low_pos_reg   <= '0;
                        any_reg       <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    pos_reg    <= in_data.sensor_position;
                    weight_reg <= weight_in;
                    last_reg   <= in_data.packet_end;
                    prod_reg   <= mul_p;
                end
            end
            S_ACC_X: prod_reg <= mul_p;
            S_PREP:
            begin
                zero_reg <= (sx_reg == '0) && (sy_reg == '0);
                if (sx_reg[SUM_BITS-1])
                begin
                    cx_reg <= -sx_ext;
                    cy_reg <= -sy_ext;
                    z_reg  <= Z_BITS'(HALF_TURN);
                end
                else
                begin
                    cx_reg <= sx_ext;
                    cy_reg <= sy_ext;
                    z_reg  <= '0;
                end
            end
            S_ITER:
            begin
                if (y_pos)
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    z_reg  <= z_reg + atan_unit(step_reg);
                end
                else
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    z_reg  <= z_reg - atan_unit(step_reg);
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_reg.ball_seen          <= any_reg;
                    out_reg.bearing            <= new_bearing;
                    out_reg.strongest_position <= low_pos_reg;
                    out_reg.strongest_reading  <= low_reg;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/irb_checker.sv =====
// Port-level checks for the infrared ring bearing estimator, bound to the top level.
`default_nettype none
module irb_checker
    import irb_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_stall,
    input wire irb_in_t                 in_data,
    input wire logic                    out_valid,
    input wire logic                    out_stall,
    input wire irb_out_t                out_data
);

    // busy after every accepted transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted on the cycle after a transaction");

    // a result appears only out of a busy period
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while idle");

    // a reading without packet end does not raise a result during its accumulation
    a_no_result_mid_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !in_data.packet_end) |=> ##1 !$rose(out_valid))
        else $error("result raised by a mid-packet reading");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

endmodule

bind ir_ring_bearing_estimator irb_checker u_irb_checker (.*);
`default_nettype wire
